>>> design/spcsf_pkg.sv
// Shared types, codes and constants of the sphere packing cell solid fraction block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package spcsf_pkg;

  localparam int MAX_SPHERES   = 1024;
  localparam int MAX_DIVISIONS = 16;
  localparam int ADDR_W        = $clog2(MAX_SPHERES);
  localparam int CNT_W         = $clog2(MAX_SPHERES + 1);
  localparam int DIV_W         = 5;
  localparam int IDX_W         = 4;
  localparam int COORD_W       = 31;
  localparam int DIFF_W        = 32;
  localparam int RS_W          = 28;
  localparam int SQ_W          = 2 * RS_W;
  localparam int CNT13_W       = 13;
  localparam int TOP_W         = 26;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  localparam logic signed [TOP_W-1:0] TOP_RESET = {1'b1, {(TOP_W-1){1'b0}}};

  // Cube of the division count, 0..16.
  localparam logic [CNT13_W-1:0] CUBE_TBL [0:16] = '{
    13'd0, 13'd1, 13'd8, 13'd27, 13'd64, 13'd125, 13'd216, 13'd343, 13'd512,
    13'd729, 13'd1000, 13'd1331, 13'd1728, 13'd2197, 13'd2744, 13'd3375, 13'd4096
  };

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_CELL = 2'd2
  } res_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUB_DIV = 3'd0,
    CFG_SIZE_X  = 3'd1,
    CFG_SIZE_Y  = 3'd2,
    CFG_SIZE_Z  = 3'd3,
    CFG_BED_EN  = 3'd4,
    CFG_BED_TOP = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SWEEP = 2'd1,
    S_DRAIN = 2'd2,
    S_POST  = 2'd3
  } state_t;

  typedef struct packed {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] cz;
    logic [22:0]        r;
  } sphere_t;

  typedef struct packed {
    logic              do_clear;
    logic              do_load;
    logic              do_eval;
    logic              issue;
    logic              last_sph;
    logic [ADDR_W-1:0] rd_addr;
    logic              wrap_k;
    logic              wrap_j;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic [CNT_W-1:0] count;
    logic             sweep_go;
    logic [IDX_W-1:0] div_m1;
    logic             pipe_empty;
  } sts_t;

endpackage

`default_nettype wire

>>> design/spcsf_ctrl.sv
// Controller: request decode, sub-cell and sphere sweep counters, result handoff.
// Depends on spcsf_pkg.
`default_nettype none

module spcsf_ctrl import spcsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] req_type,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire sts_t       sts,
  output cmd_t            cmd
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] s_r, s_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt, j_r, j_nxt, i_r, i_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept, last_s, wrap_k, wrap_j, final_t, slot_free;
  req_t              req;

  assign req       = req_t'(req_type);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_s    = ({1'b0, s_r} + CNT_W'(1)) == sts.count;
  assign wrap_k    = (k_r == sts.div_m1);
  assign wrap_j    = wrap_k && (j_r == sts.div_m1);
  assign final_t   = last_s && wrap_j && (i_r == sts.div_m1);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_CLEAR, REQ_LOAD: state_nxt = S_POST;
            REQ_EVAL:            state_nxt = sts.sweep_go ? S_SWEEP : S_POST;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: if (final_t) state_nxt = S_DRAIN;
      S_DRAIN: if (sts.pipe_empty) state_nxt = S_POST;
      S_POST:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.rd_addr  = s_r;
    cmd.last_sph = last_s;
    cmd.wrap_k   = wrap_k;
    cmd.wrap_j   = wrap_j;
    case (state_r)
      S_IDLE: begin
        cmd.do_clear = accept && (req == REQ_CLEAR);
        cmd.do_load  = accept && (req == REQ_LOAD);
        cmd.do_eval  = accept && (req == REQ_EVAL);
      end
      S_SWEEP: cmd.issue    = 1'b1;
      S_POST:  cmd.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    s_nxt = s_r;
    k_nxt = k_r;
    j_nxt = j_r;
    i_nxt = i_r;
    if (cmd.do_eval) begin
      s_nxt = '0;
      k_nxt = '0;
      j_nxt = '0;
      i_nxt = '0;
    end else if (cmd.issue) begin
      if (last_s) begin
        s_nxt = '0;
        if (wrap_k) begin
          k_nxt = '0;
          if (wrap_j) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end else begin
        s_nxt = s_r + ADDR_W'(1);
      end
    end
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      s_r         <= '0;
      k_r         <= '0;
      j_r         <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s_r         <= s_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/spcsf_dp.sv
// Datapath: configuration, sphere table memory, sub-center walk, inside-test pipeline.
// Depends on spcsf_pkg.
`default_nettype none

module spcsf_dp import spcsf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic signed [23:0]    pos_x,
  input  wire logic signed [23:0]    pos_y,
  input  wire logic signed [23:0]    pos_z,
  input  wire logic [22:0]           radius,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic [1:0]                 out_status,
  output logic [CNT13_W-1:0]         out_hit_count,
  output logic [CNT13_W-1:0]         out_sample_total
);

  // configuration
  logic [DIV_W-1:0]   sub_div_r;
  logic [22:0]        size_x_r, size_y_r, size_z_r;
  logic               bed_en_r;
  logic signed [23:0] bed_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_div_r <= DIV_W'(10);
      size_x_r  <= 23'd1024;
      size_y_r  <= 23'd1024;
      size_z_r  <= 23'd1024;
      bed_en_r  <= 1'b0;
      bed_top_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SUB_DIV: sub_div_r <= cfg_wdata[DIV_W-1:0];
        CFG_SIZE_X:  size_x_r  <= cfg_wdata[22:0];
        CFG_SIZE_Y:  size_y_r  <= cfg_wdata[22:0];
        CFG_SIZE_Z:  size_z_r  <= cfg_wdata[22:0];
        CFG_BED_EN:  bed_en_r  <= cfg_wdata[0];
        CFG_BED_TOP: bed_top_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // table state
  logic [CNT_W-1:0]        count_r;
  logic signed [TOP_W-1:0] top_r;
  logic signed [TOP_W-1:0] new_top;
  logic                    full;

  assign full    = (count_r == CNT_W'(MAX_SPHERES));
  assign new_top = TOP_W'(pos_z) + TOP_W'($signed({1'b0, radius}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      top_r   <= TOP_RESET;
    end else if (cmd.do_clear) begin
      count_r <= '0;
      top_r   <= TOP_RESET;
    end else if (cmd.do_load && !full) begin
      count_r <= count_r + CNT_W'(1);
      if (new_top > top_r) top_r <= new_top;
    end
  end

  sphere_t mem [MAX_SPHERES];
  sphere_t rd_q;

  always_ff @(posedge clk) begin
    if (cmd.do_load && !full) begin
      mem[count_r[ADDR_W-1:0]] <= '{cx: pos_x, cy: pos_y, cz: pos_z, r: radius};
    end
    rd_q <= mem[cmd.rd_addr];
  end

  // request decode values
  logic [DIV_W-1:0]        d_sat;
  logic signed [41:0]      z_scaled, top_scaled;
  logic                    in_bed, in_layer, above_low;
  logic signed [23:0]      lower;

  always_comb begin
    if (sub_div_r == '0)                            d_sat = DIV_W'(1);
    else if (sub_div_r > DIV_W'(MAX_DIVISIONS))     d_sat = DIV_W'(MAX_DIVISIONS);
    else                                            d_sat = sub_div_r;
  end

  assign lower      = bed_en_r ? bed_top_r : 24'sd0;
  assign in_bed     = bed_en_r && (pos_z < bed_top_r);
  assign above_low  = (pos_z >= lower);
  assign z_scaled   = 42'(pos_z) * 42'sd10000;
  assign top_scaled = 42'(top_r) * 42'sd10001;
  assign in_layer   = above_low && (z_scaled <= top_scaled);

  // first sub-center: 2d*p - d*size + size
  function automatic logic signed [COORD_W-1:0] first_ctr(
    input logic signed [23:0] p,
    input logic [22:0]        sz,
    input logic [DIV_W-1:0]   d
  );
    logic signed [COORD_W-1:0] p2;
    logic [COORD_W-1:0]        dsz;
    p2  = $signed({{7{p[23]}}, p}) * $signed({25'd0, d, 1'b0});
    dsz = {8'd0, sz} * {26'd0, d};
    return p2 - $signed(dsz) + $signed({8'd0, sz});
  endfunction

  logic [DIV_W-1:0]          d_r;
  logic [5:0]                scale;
  logic signed [COORD_W-1:0] bx1_r, by1_r, bz1_r, cx_r, cy_r, cz_r;
  logic signed [COORD_W-1:0] stx, sty, stz, fx, fy, fz;
  logic [CNT13_W-1:0]        hits_r, total_r;
  res_status_t               res_r;
  logic                      any_r;

  assign scale = {d_r, 1'b0};
  assign stx   = $signed({7'd0, size_x_r, 1'b0});
  assign sty   = $signed({7'd0, size_y_r, 1'b0});
  assign stz   = $signed({7'd0, size_z_r, 1'b0});
  assign fx    = first_ctr(pos_x, size_x_r, d_sat);
  assign fy    = first_ctr(pos_y, size_y_r, d_sat);
  assign fz    = first_ctr(pos_z, size_z_r, d_sat);

  always_ff @(posedge clk) begin
    if (cmd.do_eval) begin
      d_r   <= d_sat;
      bx1_r <= fx;
      by1_r <= fy;
      bz1_r <= fz;
      cx_r  <= fx;
      cy_r  <= fy;
      cz_r  <= fz;
    end else if (cmd.issue && cmd.last_sph) begin
      // advance k, carry into j and i
      if (cmd.wrap_k) begin
        cz_r <= bz1_r;
        if (cmd.wrap_j) begin
          cy_r <= by1_r;
          cx_r <= cx_r + stx;
        end else begin
          cy_r <= cy_r + sty;
        end
      end else begin
        cz_r <= cz_r + stz;
      end
    end
  end

  // inside-test pipeline
  logic                      v0_r, v1_r, v2_r, v3_r;
  logic                      l0_r, l1_r, l2_r, l3_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, z0_r;
  logic signed [DIFF_W-1:0]  dx1_r, dy1_r, dz1_r;
  logic [RS_W-1:0]           rs1_r, rs2_r;
  logic [RS_W-1:0]           ax2_r, ay2_r, az2_r;
  logic                      near2_r, near3_r;
  logic [SQ_W-1:0]           sqx3_r, sqy3_r, sqz3_r, r23_r;
  logic signed [COORD_W-1:0] csx, csy, csz;
  logic [28:0]               rs_full;
  logic [DIFF_W-1:0]         ax, ay, az;
  logic [SQ_W+1:0]           sum3;
  logic                      hit3;

  function automatic logic signed [COORD_W-1:0] scl(
    input logic signed [23:0] c,
    input logic [5:0]         s
  );
    return $signed({{7{c[23]}}, c}) * $signed({25'd0, s});
  endfunction

  assign csx     = scl(rd_q.cx, scale);
  assign csy     = scl(rd_q.cy, scale);
  assign csz     = scl(rd_q.cz, scale);
  assign rs_full = {6'd0, rd_q.r} * {23'd0, scale};
  assign ax      = dx1_r[DIFF_W-1] ? DIFF_W'(-dx1_r) : DIFF_W'(dx1_r);
  assign ay      = dy1_r[DIFF_W-1] ? DIFF_W'(-dy1_r) : DIFF_W'(dy1_r);
  assign az      = dz1_r[DIFF_W-1] ? DIFF_W'(-dz1_r) : DIFF_W'(dz1_r);
  assign sum3    = {2'd0, sqx3_r} + {2'd0, sqy3_r} + {2'd0, sqz3_r};
  assign hit3    = near3_r && (sum3 <= {2'd0, r23_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    l0_r    <= cmd.last_sph;
    x0_r    <= cx_r;
    y0_r    <= cy_r;
    z0_r    <= cz_r;
    l1_r    <= l0_r;
    dx1_r   <= {x0_r[COORD_W-1], x0_r} - {csx[COORD_W-1], csx};
    dy1_r   <= {y0_r[COORD_W-1], y0_r} - {csy[COORD_W-1], csy};
    dz1_r   <= {z0_r[COORD_W-1], z0_r} - {csz[COORD_W-1], csz};
    rs1_r   <= rs_full[RS_W-1:0];
    l2_r    <= l1_r;
    near2_r <= (ax <= {4'd0, rs1_r}) && (ay <= {4'd0, rs1_r}) && (az <= {4'd0, rs1_r});
    ax2_r   <= ax[RS_W-1:0];
    ay2_r   <= ay[RS_W-1:0];
    az2_r   <= az[RS_W-1:0];
    rs2_r   <= rs1_r;
    l3_r    <= l2_r;
    near3_r <= near2_r;
    sqx3_r  <= ax2_r * ax2_r;
    sqy3_r  <= ay2_r * ay2_r;
    sqz3_r  <= az2_r * az2_r;
    r23_r   <= rs2_r * rs2_r;
  end

  // hit accumulation and pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (cmd.do_eval) begin
      any_r <= 1'b0;
    end else if (v3_r) begin
      any_r <= l3_r ? 1'b0 : (any_r || hit3);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_clear) begin
      res_r <= ST_OK;
    end else if (cmd.do_load) begin
      res_r <= full ? ST_DROP : ST_OK;
    end else if (cmd.do_eval) begin
      res_r   <= ST_CELL;
      total_r <= CUBE_TBL[d_sat];
      hits_r  <= in_bed ? CUBE_TBL[d_sat] : '0;
    end else if (v3_r && l3_r && (any_r || hit3)) begin
      hits_r <= hits_r + CNT13_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= res_r;
      out_hit_count    <= (res_r == ST_CELL) ? hits_r : '0;
      out_sample_total <= (res_r == ST_CELL) ? total_r : '0;
    end
  end

  assign sts.full       = full;
  assign sts.count      = count_r;
  assign sts.sweep_go   = in_layer && !in_bed;
  assign sts.div_m1     = IDX_W'(d_r - DIV_W'(1));
  assign sts.pipe_empty = !(v0_r || v1_r || v2_r || v3_r);

endmodule

`default_nettype wire

>>> design/sphere_packing_cell_solid_fraction.sv
// Solid fraction of a cell inside a union of loaded spheres, by sub-cell sampling.
// Requests enter on in_valid/in_stall: clear table, load one sphere, or evaluate a cell.
// Every clear, load and evaluate request gives one result on out_valid/out_stall;
// request type 3 is dropped with no result.
// Clear and load: the result is loaded from the post state when the output is free.
// Evaluate in the layer: the shared inside-test pipeline checks one sphere per
// cycle, every loaded sphere against each of the d^3 sub-centers (d = sub-cells
// per axis); in the bed or outside the layer no sphere test is run.
// One request is worked at a time; the next is taken as soon as the previous
// result sits in the output register, even if the receiver has not taken it.
// While out_stall holds, the output register keeps its result and a finished
// result waits in the datapath until the register frees up.
// The user must write configuration (cfg_we, cfg_index, cfg_wdata) only while idle;
// the block does not enforce this. Reset (rst_n low, synchronous) empties the table,
// restores register defaults and drops any pending result; the sphere memory itself is not cleared.
// Depends on spcsf_pkg, spcsf_ctrl and spcsf_dp.
`default_nettype none

module sphere_packing_cell_solid_fraction import spcsf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_req_type,
  input  wire logic signed [23:0]    in_pos_x,
  input  wire logic signed [23:0]    in_pos_y,
  input  wire logic signed [23:0]    in_pos_z,
  input  wire logic [22:0]           in_radius,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [CNT13_W-1:0]         out_hit_count,
  output logic [CNT13_W-1:0]         out_sample_total
);

  cmd_t cmd;
  sts_t sts;

  spcsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (in_req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  spcsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pos_x            (in_pos_x),
    .pos_y            (in_pos_y),
    .pos_z            (in_pos_z),
    .radius           (in_radius),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_hit_count    (out_hit_count),
    .out_sample_total (out_sample_total)
  );

`ifndef ASSERT_OFF
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> in_stall)
    else $error("sphere test issued while requests are open");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a stalled output");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(MAX_SPHERES))
    else $error("sphere count beyond table depth");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_clear, cmd.do_load, cmd.do_eval}))
    else $error("more than one request decoded");
`endif

endmodule

`default_nettype wire
